>>> src/hgcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgcd_pkg: shared definitions for the great-circle distance unit
// Fixed-point constants, the CORDIC arctangent table, pipeline depths and
// helper functions used by the datapath modules.
// ----------------------------------------------------------------------------
package hgcd_pkg;

    // Number of CORDIC micro-rotations in both the rotation and vectoring units.
    localparam int CORDIC_STAGES = 24;
    // Bit-pair steps of the square root; one per register stage.
    localparam int SQRT_STEPS    = 32;
    // Degree conversion (five stages) followed by the rotation stages.
    localparam int SINCOS_DEPTH  = 5 + CORDIC_STAGES;
    // Register stages between the input transfer and the output register.
    localparam int PIPE_DEPTH    = 43 + 2 * CORDIC_STAGES;

    // Width of CORDIC and Q30 datapath words.
    localparam int CW = 34;
    typedef logic signed [CW-1:0] cval_t;

    localparam logic [31:0]        PI_Q30      = 32'd3373259426;
    localparam cval_t              PI_S        = 34'sd3373259426;
    localparam cval_t              HALF_PI     = 34'sd1686629713;
    localparam cval_t              GAIN_INV    = 34'sd652032874;
    localparam logic signed [32:0] DEG_HALF    = 33'sd754974720;
    localparam logic signed [32:0] DEG_FULL    = 33'sd1509949440;
    // Rounding biases: half the divisor for whole and half angles.
    localparam logic [61:0]        BIAS_FULL   = 62'd377487360;
    localparam logic [61:0]        BIAS_HALF   = 62'd754974720;
    // floor(2^38 / 45), used to divide the shifted product by 45.
    localparam logic [32:0]        RECIP_45    = 33'd6108397932;
    localparam logic [37:0]        DIV_45      = 38'd45;
    localparam logic [22:0]        EARTH_R     = 23'd6371000;
    localparam logic [24:0]        DIST_MAX    = 25'd20015087;
    localparam logic [30:0]        Q30_ONE     = 31'd1073741824;

    // Magnitude and sign of an angle in degree units, wrapped to a half turn.
    typedef struct packed {
        logic        neg;
        logic [29:0] mag;
    } ang_t;

    // Wrap a degree value into [-180, 180) and split it into sign and magnitude.
    function automatic ang_t wrap_deg(input logic signed [32:0] d);
        logic signed [32:0] w;
        ang_t               r;
        if (d >= DEG_HALF) begin
            w = d - DEG_FULL;
        end else if (d < -DEG_HALF) begin
            w = d + DEG_FULL;
        end else begin
            w = d;
        end
        r.neg = w[32];
        r.mag = w[32] ? 30'(-w) : 30'(w);
        return r;
    endfunction

    // Arctangent of 2^-i in Q30 radians.
    function automatic cval_t atan_q30(input int unsigned i);
        cval_t t;
        unique case (i)
            0:       t = 34'sd843314857;
            1:       t = 34'sd497837829;
            2:       t = 34'sd263043837;
            3:       t = 34'sd133525159;
            4:       t = 34'sd67021687;
            5:       t = 34'sd33543516;
            6:       t = 34'sd16775851;
            7:       t = 34'sd8388437;
            8:       t = 34'sd4194283;
            9:       t = 34'sd2097149;
            10:      t = 34'sd1048576;
            11:      t = 34'sd524288;
            12:      t = 34'sd262144;
            13:      t = 34'sd131072;
            14:      t = 34'sd65536;
            15:      t = 34'sd32768;
            16:      t = 34'sd16384;
            17:      t = 34'sd8192;
            18:      t = 34'sd4096;
            19:      t = 34'sd2048;
            20:      t = 34'sd1024;
            21:      t = 34'sd512;
            22:      t = 34'sd256;
            23:      t = 34'sd128;
            24:      t = 34'sd64;
            25:      t = 34'sd32;
            26:      t = 34'sd16;
            27:      t = 34'sd8;
            28:      t = 34'sd4;
            29:      t = 34'sd2;
            30:      t = 34'sd1;
            default: t = '0;
        endcase
        return t;
    endfunction

    // Q30 product with round-half-up.
    function automatic cval_t mul_q30(input cval_t a, input cval_t b);
        logic signed [2*CW-1:0] p;
        p = a * b + 68'sd536870912;
        return cval_t'(p >>> 30);
    endfunction

endpackage

>>> src/hgcd_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgcd_sincos: degree-to-radian conversion and rotation CORDIC
// Converts one wrapped angle to Q30 radians (optionally halved), folds it
// into [-pi/2, pi/2] and runs one CORDIC micro-rotation per register stage.
// ----------------------------------------------------------------------------
module hgcd_sincos (
    input  logic           clk,
    input  logic           en,
    input  logic           half,
    input  hgcd_pkg::ang_t ang,
    output hgcd_pkg::cval_t sin_out,
    output hgcd_pkg::cval_t cos_out
);
    import hgcd_pkg::*;

    logic [61:0]  num_next, num_reg;
    logic         neg_b_reg, neg_c_reg, neg_d_reg;
    logic [37:0]  np_next, np_c_reg, np_d_reg;
    logic [64:0]  plo_next, plo_reg;
    logic [38:0]  phi_next, phi_reg;
    logic [70:0]  full_prod;
    logic [31:0]  q0_next, q0_reg;
    logic [37:0]  rem;
    logic [31:0]  q_fix;
    cval_t        zq, z_next, z_e_reg;
    cval_t        zf_next, z_f_reg;
    logic         flip_next, flip_f_reg;

    cval_t        x_reg [CORDIC_STAGES];
    cval_t        y_reg [CORDIC_STAGES];
    cval_t        z_reg [CORDIC_STAGES];
    logic         f_reg [CORDIC_STAGES];
    cval_t        x_next [CORDIC_STAGES];
    cval_t        y_next [CORDIC_STAGES];
    cval_t        z_next_r [CORDIC_STAGES];
    logic         f_next [CORDIC_STAGES];
    cval_t        xi, yi, zi, dx, dy;
    logic         fi;

    // Scale by pi and add the rounding bias.
    assign num_next = 62'(ang.mag) * 62'(PI_Q30) + (half ? BIAS_HALF : BIAS_FULL);

    // Drop the power-of-two part of the divisor and start the divide by 45.
    assign np_next  = half ? {1'b0, num_reg[61:25]} : num_reg[61:24];
    assign plo_next = 65'(np_next[31:0]) * 65'(RECIP_45);
    assign phi_next = 39'(np_next[37:32]) * 39'(RECIP_45);

    // Combine the partial products; the estimate is exact or one low.
    assign full_prod = 71'(plo_reg) + (71'(phi_reg) << 32);
    assign q0_next   = full_prod[69:38];

    // Correct the estimate and restore the sign.
    assign rem    = np_d_reg - 38'(q0_reg) * DIV_45;
    assign q_fix  = q0_reg + 32'(rem >= DIV_45);
    assign zq     = cval_t'({2'b00, q_fix});
    assign z_next = neg_d_reg ? -zq : zq;

    // Fold angles beyond a quarter turn; the cosine changes sign.
    always_comb
    begin
        if (z_e_reg > HALF_PI) begin
            zf_next   = PI_S - z_e_reg;
            flip_next = 1'b1;
        end else if (z_e_reg < -HALF_PI) begin
            zf_next   = -PI_S - z_e_reg;
            flip_next = 1'b1;
        end else begin
            zf_next   = z_e_reg;
            flip_next = 1'b0;
        end
    end

    // One micro-rotation per stage.
    always_comb
    begin
        xi = '0;
        yi = '0;
        zi = '0;
        dx = '0;
        dy = '0;
        fi = 1'b0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xi = (i == 0) ? GAIN_INV   : x_reg[i-1];
            yi = (i == 0) ? '0         : y_reg[i-1];
            zi = (i == 0) ? z_f_reg    : z_reg[i-1];
            fi = (i == 0) ? flip_f_reg : f_reg[i-1];
            dx = yi >>> i;
            dy = xi >>> i;
            if (zi[CW-1]) begin
                x_next[i]   = xi + dx;
                y_next[i]   = yi - dy;
                z_next_r[i] = zi + atan_q30(i);
            end else begin
                x_next[i]   = xi - dx;
                y_next[i]   = yi + dy;
                z_next_r[i] = zi - atan_q30(i);
            end
            f_next[i] = fi;
        end
    end

    // Pipeline registers; all stages advance together.
    always_ff @(posedge clk)
    begin
        if (en) begin
            num_reg    <= num_next;
            neg_b_reg  <= ang.neg;
            np_c_reg   <= np_next;
            plo_reg    <= plo_next;
            phi_reg    <= phi_next;
            neg_c_reg  <= neg_b_reg;
            q0_reg     <= q0_next;
            np_d_reg   <= np_c_reg;
            neg_d_reg  <= neg_c_reg;
            z_e_reg    <= z_next;
            z_f_reg    <= zf_next;
            flip_f_reg <= flip_next;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                x_reg[i] <= x_next[i];
                y_reg[i] <= y_next[i];
                z_reg[i] <= z_next_r[i];
                f_reg[i] <= f_next[i];
            end
        end
    end

    assign sin_out = y_reg[CORDIC_STAGES-1];
    assign cos_out = f_reg[CORDIC_STAGES-1] ? -x_reg[CORDIC_STAGES-1]
                                            : x_reg[CORDIC_STAGES-1];

endmodule

>>> src/hgcd_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgcd_sqrt: pipelined Q30 square root
// Floor square root of (value << 30), one bit pair per register stage.
// ----------------------------------------------------------------------------
module hgcd_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [30:0] value,
    output logic [30:0] root
);
    import hgcd_pkg::*;

    logic [63:0] n_reg  [SQRT_STEPS];
    logic [63:0] r_reg  [SQRT_STEPS];
    logic [63:0] n_next [SQRT_STEPS];
    logic [63:0] r_next [SQRT_STEPS];
    logic [63:0] n_in, r_in, bit_v, trial;

    // Restoring square root step: try the next result bit.
    always_comb
    begin
        n_in  = '0;
        r_in  = '0;
        bit_v = '0;
        trial = '0;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            n_in  = (k == 0) ? {3'b000, value, 30'd0} : n_reg[k-1];
            r_in  = (k == 0) ? 64'd0 : r_reg[k-1];
            bit_v = 64'd1 << (62 - 2 * k);
            trial = r_in + bit_v;
            if (n_in >= trial) begin
                n_next[k] = n_in - trial;
                r_next[k] = (r_in >> 1) + bit_v;
            end else begin
                n_next[k] = n_in;
                r_next[k] = r_in >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                n_reg[k] <= n_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQRT_STEPS-1][30:0];

endmodule

>>> src/haversine_great_circle_distance_unit.sv
`timescale 1ns / 1ps
// Input data passes the angle registers, sine/cosine lanes, term registers, square
// roots, vectoring CORDIC and product register on its way to the output register.
// Throughput: one coordinate pair per cycle unless stalled; stages move together.
// The output register plus one skid entry absorb a stalled consumer.
// Reset (rst_n, asynchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_unit: great-circle distance pipeline
// Haversine distance in meters between two fixed-point coordinates using
// CORDIC sine/cosine, pipelined square roots and a vectoring CORDIC.
// ----------------------------------------------------------------------------
module haversine_great_circle_distance_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [29:0] from_latitude,
    input  logic signed [30:0] from_longitude,
    input  logic signed [29:0] to_latitude,
    input  logic signed [30:0] to_longitude,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [24:0]        distance_m
);
    import hgcd_pkg::*;

    logic               en;
    logic               v_reg [PIPE_DEPTH];
    logic signed [32:0] dlat_w, dlon_w;
    ang_t               ang_next [4];
    ang_t               ang_reg  [4];
    cval_t              sn [4];
    cval_t              cs [4];

    cval_t              s2lat_next, s2lon_next, s2lat_reg, s2lon_reg;
    cval_t              c1_reg, c2_reg, c2_m2_reg;
    cval_t              u_next, u_reg, s2lat_m2_reg;
    cval_t              t2_next, t2_reg, s2lat_m3_reg;
    logic signed [34:0] asum;
    logic [30:0]        a_next, a_reg, b_reg;
    logic [30:0]        root_a, root_b;

    cval_t              vx_reg  [CORDIC_STAGES];
    cval_t              vy_reg  [CORDIC_STAGES];
    cval_t              vz_reg  [CORDIC_STAGES];
    cval_t              vx_next [CORDIC_STAGES];
    cval_t              vy_next [CORDIC_STAGES];
    cval_t              vz_next [CORDIC_STAGES];
    cval_t              xi, yi, zi, dx, dy;

    cval_t              cdbl;
    logic [31:0]        c_pos;
    logic [54:0]        prod_next, prod_reg;
    logic [55:0]        rnd;
    logic [25:0]        dq;
    logic [24:0]        dist_next;

    logic               push, pop;
    logic               out_valid_reg, skid_valid_reg;
    logic [24:0]        out_data_reg, skid_data_reg;

    // Stall the whole pipeline only when the skid entry is occupied.
    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // Angle differences and both latitudes, each wrapped to a half turn.
    assign dlat_w = {{3{to_latitude[29]}}, to_latitude}
                  - {{3{from_latitude[29]}}, from_latitude};
    assign dlon_w = {{2{to_longitude[30]}}, to_longitude}
                  - {{2{from_longitude[30]}}, from_longitude};
    assign ang_next[0] = wrap_deg(dlat_w);
    assign ang_next[1] = wrap_deg(dlon_w);
    assign ang_next[2] = wrap_deg({{3{from_latitude[29]}}, from_latitude});
    assign ang_next[3] = wrap_deg({{3{to_latitude[29]}}, to_latitude});

    // Sine and cosine lanes: two half angles, two whole latitudes.
    for (genvar gl = 0; gl < 4; gl++) begin : g_lane
        hgcd_sincos u_sincos (
            .clk     (clk),
            .en      (en),
            .half    (gl < 2),
            .ang     (ang_reg[gl]),
            .sin_out (sn[gl]),
            .cos_out (cs[gl])
        );
    end

    // Haversine term products.
    assign s2lat_next = mul_q30(sn[0], sn[0]);
    assign s2lon_next = mul_q30(sn[1], sn[1]);
    assign u_next     = mul_q30(s2lon_reg, c1_reg);
    assign t2_next    = mul_q30(u_reg, c2_m2_reg);

    // Sum and clamp the term to [0, 1].
    assign asum = {s2lat_m3_reg[CW-1], s2lat_m3_reg} + {t2_reg[CW-1], t2_reg};
    always_comb
    begin
        if (asum[34]) begin
            a_next = '0;
        end else if (asum > 35'sd1073741824) begin
            a_next = Q30_ONE;
        end else begin
            a_next = asum[30:0];
        end
    end

    hgcd_sqrt u_sqrt_a (
        .clk   (clk),
        .en    (en),
        .value (a_reg),
        .root  (root_a)
    );

    hgcd_sqrt u_sqrt_b (
        .clk   (clk),
        .en    (en),
        .value (b_reg),
        .root  (root_b)
    );

    // Vectoring CORDIC: angle of (sqrt(1-a), sqrt(a)).
    always_comb
    begin
        xi = '0;
        yi = '0;
        zi = '0;
        dx = '0;
        dy = '0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xi = (i == 0) ? cval_t'({3'b000, root_b}) : vx_reg[i-1];
            yi = (i == 0) ? cval_t'({3'b000, root_a}) : vy_reg[i-1];
            zi = (i == 0) ? '0 : vz_reg[i-1];
            dx = yi >>> i;
            dy = xi >>> i;
            if (!yi[CW-1]) begin
                vx_next[i] = xi + dx;
                vy_next[i] = yi - dy;
                vz_next[i] = zi + atan_q30(i);
            end else begin
                vx_next[i] = xi - dx;
                vy_next[i] = yi + dy;
                vz_next[i] = zi - atan_q30(i);
            end
        end
    end

    // Central angle times the radius; a negative residue counts as zero.
    assign cdbl      = vz_reg[CORDIC_STAGES-1] <<< 1;
    assign c_pos     = cdbl[CW-1] ? 32'd0 : cdbl[31:0];
    assign prod_next = 55'(c_pos) * 55'(EARTH_R);

    // Round to meters and saturate at half the circumference.
    assign rnd       = 56'(prod_reg) + 56'd536870912;
    assign dq        = rnd[55:30];
    assign dist_next = (dq > 26'(DIST_MAX)) ? DIST_MAX : dq[24:0];

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                ang_reg[j] <= ang_next[j];
            end
            s2lat_reg    <= s2lat_next;
            s2lon_reg    <= s2lon_next;
            c1_reg       <= cs[2];
            c2_reg       <= cs[3];
            u_reg        <= u_next;
            s2lat_m2_reg <= s2lat_reg;
            c2_m2_reg    <= c2_reg;
            t2_reg       <= t2_next;
            s2lat_m3_reg <= s2lat_m2_reg;
            a_reg        <= a_next;
            b_reg        <= Q30_ONE - a_next;
            for (int i = 0; i < CORDIC_STAGES; i++) begin
                vx_reg[i] <= vx_next[i];
                vy_reg[i] <= vy_next[i];
                vz_reg[i] <= vz_next[i];
            end
            prod_reg     <= prod_next;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (en) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Output register with one skid entry.
    assign push = en && v_reg[PIPE_DEPTH-1];
    assign pop  = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (pop) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (push) begin
                if (!out_valid_reg || pop) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= dist_next;
            end else begin
                skid_data_reg <= dist_next;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign distance_m = out_data_reg;

endmodule

>>> src/hgcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgcd_checker: port-level checks for the distance unit
// Watches the handshakes and the result range at the top-level ports.
// ----------------------------------------------------------------------------
module hgcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [24:0] distance_m
);
    import hgcd_pkg::*;

    // A delivered distance never exceeds half the circumference.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> distance_m <= DIST_MAX)
        else $error("distance above half circumference");

    // The input side stalls only while a result is waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no pending result");

    // Taking a result frees room for the next input transfer.
    a_ready_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("input not ready after an output transfer");

    // A result held by the consumer stays valid and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance_m))
        else $error("pending result dropped or changed");

endmodule

bind haversine_great_circle_distance_unit hgcd_checker u_hgcd_checker (.*);
